### sv/vl3r_pkg.sv
// shared types and constants of the 3d voxel line rasterizer
`timescale 1ns / 1ps

package vl3r_pkg;

    localparam int COORD_W = 3;
    localparam int LEVEL_W = 12;
    // |delta_minor| * t stays below 64 for 3-bit coordinates
    localparam int NUM_W   = 6;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [NUM_W-1:0]   num_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    // endpoint pair of one line command
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } endpoints_t;

    // line setup: major axis, ordered base point and minor slopes
    typedef struct packed {
        axis_t  major;
        coord_t maj_lo;
        coord_t len;
        coord_t m1_start;
        coord_t m1_mag;
        logic   m1_neg;
        coord_t m2_start;
        coord_t m2_mag;
        logic   m2_neg;
    } line_setup_t;

    // request into the shared divider
    typedef struct packed {
        logic   start;
        num_t   num;
        coord_t den;
    } div_req_t;

    // response from the shared divider
    typedef struct packed {
        logic   done;
        coord_t quot;
    } div_rsp_t;

endpackage

### sv/vl3r_if.sv
// valid/ready channel interfaces for line commands and voxels
`timescale 1ns / 1ps

interface vl3r_cmd_if;
    import vl3r_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    level_t red_level;
    level_t green_level;
    level_t blue_level;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               red_level, green_level, blue_level,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               red_level, green_level, blue_level,
        output ready
    );
endinterface

interface vl3r_voxel_if;
    import vl3r_pkg::*;

    logic   valid;
    logic   ready;
    coord_t voxel_x;
    coord_t voxel_y;
    coord_t voxel_z;
    level_t out_red;
    level_t out_green;
    level_t out_blue;
    logic   last_voxel;

    modport source (
        output valid, voxel_x, voxel_y, voxel_z, out_red, out_green, out_blue,
               last_voxel,
        input  ready
    );
    modport sink (
        input  valid, voxel_x, voxel_y, voxel_z, out_red, out_green, out_blue,
               last_voxel,
        output ready
    );
endinterface

### sv/vl3r_setup.sv
// line setup: spans, major axis choice, endpoint ordering and minor slopes
`timescale 1ns / 1ps

module vl3r_setup (
    input  vl3r_pkg::endpoints_t  pts,
    output vl3r_pkg::line_setup_t setup
);
    import vl3r_pkg::*;

    coord_t dx, dy, dz;
    axis_t  major;
    coord_t a0, a1, b0, b1, c0, c1;
    logic   swap;
    coord_t b_lo, b_hi, c_lo, c_hi;

    // per-axis spans
    always_comb
    begin
        dx = (pts.start_x >= pts.end_x) ? pts.start_x - pts.end_x : pts.end_x - pts.start_x;
        dy = (pts.start_y >= pts.end_y) ? pts.start_y - pts.end_y : pts.end_y - pts.start_y;
        dz = (pts.start_z >= pts.end_z) ? pts.start_z - pts.end_z : pts.end_z - pts.start_z;
    end

    // major axis, ties go x then y then z
    always_comb
    begin
        if (dx >= dy && dx >= dz)
            major = AX_X;
        else if (dy >= dz)
            major = AX_Y;
        else
            major = AX_Z;
    end

    // route coordinates into major / first minor / second minor
    always_comb
    begin
        case (major)
            AX_Y:
            begin
                a0 = pts.start_y; a1 = pts.end_y;
                b0 = pts.start_x; b1 = pts.end_x;
                c0 = pts.start_z; c1 = pts.end_z;
            end
            AX_Z:
            begin
                a0 = pts.start_z; a1 = pts.end_z;
                b0 = pts.start_x; b1 = pts.end_x;
                c0 = pts.start_y; c1 = pts.end_y;
            end
            default:
            begin
                a0 = pts.start_x; a1 = pts.end_x;
                b0 = pts.start_y; b1 = pts.end_y;
                c0 = pts.start_z; c1 = pts.end_z;
            end
        endcase
    end

    // order endpoints so the major coordinate rises
    always_comb
    begin
        swap = (a0 > a1);
        b_lo = swap ? b1 : b0;
        b_hi = swap ? b0 : b1;
        c_lo = swap ? c1 : c0;
        c_hi = swap ? c0 : c1;

        setup.major    = major;
        setup.maj_lo   = swap ? a1 : a0;
        setup.len      = swap ? a0 - a1 : a1 - a0;
        setup.m1_start = b_lo;
        setup.m1_neg   = (b_hi < b_lo);
        setup.m1_mag   = (b_hi < b_lo) ? b_lo - b_hi : b_hi - b_lo;
        setup.m2_start = c_lo;
        setup.m2_neg   = (c_hi < c_lo);
        setup.m2_mag   = (c_hi < c_lo) ? c_lo - c_hi : c_hi - c_lo;
    end

endmodule

### sv/vl3r_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module vl3r_div (
    input  logic               clk,
    input  logic               rst_n,
    input  vl3r_pkg::div_req_t req,
    output vl3r_pkg::div_rsp_t rsp
);
    import vl3r_pkg::*;

    logic       busy_reg;
    logic       done_reg;
    logic [1:0] cnt_reg;
    num_t       rem_reg;
    coord_t     den_reg;
    coord_t     quot_reg;
    num_t       den_shift;
    logic       take;

    // trial subtract of the shifted divisor; a zero divisor yields zero
    always_comb
    begin
        den_shift = num_t'({{(NUM_W-COORD_W){1'b0}}, den_reg} << cnt_reg);
        take      = (den_reg != '0) && (rem_reg >= den_shift);
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == 2'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder, quotient and bit counter
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            den_reg  <= req.den;
            cnt_reg  <= 2'd2;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg           <= rem_reg - den_shift;
                quot_reg[cnt_reg] <= 1'b1;
            end
            if (cnt_reg != 2'd0)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

### sv/voxel_line_3d_rasterizer.sv
// top level of the 3d voxel line rasterizer
//
//  channel  | dir | carries
//  ---------+-----+---------------------------------------------------
//  cmd      | in  | two endpoints and the rgb colour of one line
//  voxel    | out | one voxel per major-axis step, last one flagged
//
// a line of n voxels is produced one voxel at a time: each voxel runs two
// 3-step divisions in turn through the one shared divider, then waits in
// S_EMIT until the voxel channel takes it.
// cmd.ready is high only while idle; a stalled voxel holds until taken.
// a command with a coordinate at EDGE_LEN or above produces no voxels.
// reset returns the sequencer to idle with no voxel pending.
`timescale 1ns / 1ps

module voxel_line_3d_rasterizer #(
    parameter int EDGE_LEN = 8
) (
    input logic         clk,
    input logic         rst_n,
    vl3r_cmd_if.sink    cmd,
    vl3r_voxel_if.source voxel
);
    import vl3r_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DIV1_GO   = 6'b000010,
        S_DIV1_WAIT = 6'b000100,
        S_DIV2_GO   = 6'b001000,
        S_DIV2_WAIT = 6'b010000,
        S_EMIT      = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    endpoints_t  pts;
    line_setup_t setup;
    line_setup_t line_reg;
    level_t      red_reg, green_reg, blue_reg;
    coord_t      t_reg;
    num_t        num1_reg, num2_reg;
    coord_t      v1_reg, v2_reg;
    coord_t      maj_coord;
    logic        in_range;
    logic        last;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // line setup from the command payload
    assign pts = '{start_x: cmd.start_x, start_y: cmd.start_y, start_z: cmd.start_z,
                   end_x: cmd.end_x, end_y: cmd.end_y, end_z: cmd.end_z};

    vl3r_setup u_setup (
        .pts   (pts),
        .setup (setup)
    );

    // endpoints must lie inside the cube
    assign in_range = (32'(cmd.start_x) < EDGE_LEN) && (32'(cmd.start_y) < EDGE_LEN) &&
                      (32'(cmd.start_z) < EDGE_LEN) && (32'(cmd.end_x) < EDGE_LEN) &&
                      (32'(cmd.end_y) < EDGE_LEN) && (32'(cmd.end_z) < EDGE_LEN);

    // shared divider, fed with one minor numerator at a time
    assign div_req.start = (state_reg == S_DIV1_GO) || (state_reg == S_DIV2_GO);
    assign div_req.num   = (state_reg == S_DIV2_GO) ? num2_reg : num1_reg;
    assign div_req.den   = line_reg.len;

    vl3r_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign last = (t_reg == line_reg.len);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (cmd.valid && in_range)
                    state_next = S_DIV1_GO;
            S_DIV1_GO:
                state_next = S_DIV1_WAIT;
            S_DIV1_WAIT:
                if (div_rsp.done)
                    state_next = S_DIV2_GO;
            S_DIV2_GO:
                state_next = S_DIV2_WAIT;
            S_DIV2_WAIT:
                if (div_rsp.done)
                    state_next = S_EMIT;
            S_EMIT:
                if (voxel.ready)
                    state_next = last ? S_IDLE : S_DIV1_GO;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // line registers, step counter and running numerators
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd.valid)
        begin
            line_reg  <= setup;
            red_reg   <= cmd.red_level;
            green_reg <= cmd.green_level;
            blue_reg  <= cmd.blue_level;
            t_reg     <= '0;
            num1_reg  <= '0;
            num2_reg  <= '0;
        end
        else if (state_reg == S_EMIT && voxel.ready && !last)
        begin
            t_reg    <= t_reg + 1'b1;
            num1_reg <= num1_reg + num_t'(line_reg.m1_mag);
            num2_reg <= num2_reg + num_t'(line_reg.m2_mag);
        end
    end

    // minor coordinates from the quotients
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV1_WAIT && div_rsp.done)
            v1_reg <= line_reg.m1_neg ? line_reg.m1_start - div_rsp.quot
                                      : line_reg.m1_start + div_rsp.quot;
        if (state_reg == S_DIV2_WAIT && div_rsp.done)
            v2_reg <= line_reg.m2_neg ? line_reg.m2_start - div_rsp.quot
                                      : line_reg.m2_start + div_rsp.quot;
    end

    // map major / minor back to x, y, z
    assign maj_coord = line_reg.maj_lo + t_reg;

    always_comb
    begin
        case (line_reg.major)
            AX_Y:
            begin
                voxel.voxel_x = v1_reg;
                voxel.voxel_y = maj_coord;
                voxel.voxel_z = v2_reg;
            end
            AX_Z:
            begin
                voxel.voxel_x = v1_reg;
                voxel.voxel_y = v2_reg;
                voxel.voxel_z = maj_coord;
            end
            default:
            begin
                voxel.voxel_x = maj_coord;
                voxel.voxel_y = v1_reg;
                voxel.voxel_z = v2_reg;
            end
        endcase
    end

    // channel outputs
    assign cmd.ready        = (state_reg == S_IDLE);
    assign voxel.valid      = (state_reg == S_EMIT);
    assign voxel.out_red    = red_reg;
    assign voxel.out_green  = green_reg;
    assign voxel.out_blue   = blue_reg;
    assign voxel.last_voxel = last;

endmodule

### sv/vl3r_checker.sv
// port-level checks of the rasterizer and their bind to the top level
`timescale 1ns / 1ps

module vl3r_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        vox_valid,
    input logic        vox_ready,
    input logic        vox_last,
    input logic [45:0] vox_data
);

    // a command is never taken while a voxel is pending
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ready && vox_valid))
        else $error("command ready while a voxel is pending");

    // a stalled voxel holds its payload
    a_vox_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vox_valid && !vox_ready |=> vox_valid && $stable(vox_data))
        else $error("stalled voxel changed");

    // after the last voxel transfer the block is idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        vox_valid && vox_ready && vox_last |=> cmd_ready && !vox_valid)
        else $error("not idle after the last voxel");

    // a line that is not finished keeps the command side closed
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        vox_valid && vox_ready && !vox_last |=> !cmd_ready)
        else $error("command ready in the middle of a line");

    // a taken command is never answered in the cycle that follows
    a_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !vox_valid)
        else $error("voxel right after command transfer");

endmodule

bind voxel_line_3d_rasterizer vl3r_checker u_vl3r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .vox_valid (voxel.valid),
    .vox_ready (voxel.ready),
    .vox_last  (voxel.last_voxel),
    .vox_data  ({voxel.voxel_x, voxel.voxel_y, voxel.voxel_z, voxel.out_red,
                 voxel.out_green, voxel.out_blue, voxel.last_voxel})
);

### sim/vl3r_line_checker.sv
// line checker: watches both channels, predicts voxels and compares them
`timescale 1ns / 1ps

module vl3r_line_checker (
    input  logic         clk,
    input  logic         rst_n,
    vl3r_cmd_if          cmd,
    vl3r_voxel_if        voxel,
    output int           fail_count,
    output int           voxels_owed
);
    import vl3r_pkg::*;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        level_t red;
        level_t green;
        level_t blue;
        logic   last;
    } voxel_item_t;

    voxel_item_t expected_voxels[$];

    initial
    begin
        fail_count  = 0;
        voxels_owed = 0;
    end

    // count a failure, report only the first ten
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%t: %s", $realtime, msg);
        end
    endfunction

    // walk the line along its major axis and queue one voxel per step
    function automatic void rasterize_line(input endpoints_t ep, input level_t r,
                                           input level_t g, input level_t b);
        int          lo[3];
        int          hi[3];
        int          tmp[3];
        int          span[3];
        int          pos[3];
        int          mj;
        int          m1;
        int          m2;
        int          len;
        int          i;
        axis_t       major;
        voxel_item_t v;

        lo = '{int'(ep.start_x), int'(ep.start_y), int'(ep.start_z)};
        hi = '{int'(ep.end_x), int'(ep.end_y), int'(ep.end_z)};
        for (i = 0; i < 3; i++)
        begin
            span[i] = (lo[i] >= hi[i]) ? lo[i] - hi[i] : hi[i] - lo[i];
        end

        // greatest span wins, ties go to x, then y
        if (span[0] >= span[1] && span[0] >= span[2])
            major = AX_X;
        else if (span[1] >= span[2])
            major = AX_Y;
        else
            major = AX_Z;

        case (major)
            AX_X:
            begin
                m1 = 1;
                m2 = 2;
            end
            AX_Y:
            begin
                m1 = 0;
                m2 = 2;
            end
            default:
            begin
                m1 = 0;
                m2 = 1;
            end
        endcase
        mj = int'(major);

        // order endpoints so the major coordinate rises
        if (lo[mj] > hi[mj])
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        len = hi[mj] - lo[mj];

        // minor offsets use division truncated toward zero
        for (i = 0; i <= len; i++)
        begin
            pos[mj] = lo[mj] + i;
            if (len == 0)
            begin
                pos[m1] = lo[m1];
                pos[m2] = lo[m2];
            end
            else
            begin
                pos[m1] = lo[m1] + ((hi[m1] - lo[m1]) * i) / len;
                pos[m2] = lo[m2] + ((hi[m2] - lo[m2]) * i) / len;
            end
            v.x     = coord_t'(pos[0]);
            v.y     = coord_t'(pos[1]);
            v.z     = coord_t'(pos[2]);
            v.red   = r;
            v.green = g;
            v.blue  = b;
            v.last  = (i == len);
            expected_voxels.push_back(v);
        end
    endfunction

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        voxel_item_t want;
        endpoints_t  ep;

        if (rst_n)
        begin
            // command transfer: queue its voxels
            if (cmd.valid && cmd.ready)
            begin
                ep.start_x = cmd.start_x;
                ep.start_y = cmd.start_y;
                ep.start_z = cmd.start_z;
                ep.end_x   = cmd.end_x;
                ep.end_y   = cmd.end_y;
                ep.end_z   = cmd.end_z;
                rasterize_line(ep, cmd.red_level, cmd.green_level, cmd.blue_level);
            end

            // voxel transfer: compare with the oldest expectation
            if (voxel.valid && voxel.ready)
            begin
                if (expected_voxels.size() == 0)
                begin
                    note_failure($sformatf(
                        "voxel with nothing expected: xyz=%0d,%0d,%0d rgb=%03h/%03h/%03h last=%0b",
                        voxel.voxel_x, voxel.voxel_y, voxel.voxel_z,
                        voxel.out_red, voxel.out_green, voxel.out_blue, voxel.last_voxel));
                end
                else
                begin
                    want = expected_voxels.pop_front();
                    if (voxel.voxel_x !== want.x || voxel.voxel_y !== want.y ||
                        voxel.voxel_z !== want.z || voxel.out_red !== want.red ||
                        voxel.out_green !== want.green || voxel.out_blue !== want.blue ||
                        voxel.last_voxel !== want.last)
                    begin
                        note_failure($sformatf(
                            {"voxel mismatch: expected xyz=%0d,%0d,%0d rgb=%03h/%03h/%03h ",
                             "last=%0b, got xyz=%0d,%0d,%0d rgb=%03h/%03h/%03h last=%0b"},
                            want.x, want.y, want.z, want.red, want.green, want.blue,
                            want.last, voxel.voxel_x, voxel.voxel_y, voxel.voxel_z,
                            voxel.out_red, voxel.out_green, voxel.out_blue,
                            voxel.last_voxel));
                    end
                end
            end
            voxels_owed = expected_voxels.size();
        end
    end

endmodule

### sim/tb_voxel_line_3d_rasterizer.sv
// testbench top: line command stimulus, voxel sink and final verdict
`timescale 1ns / 1ps

module tb_voxel_line_3d_rasterizer;
    import vl3r_pkg::*;

    localparam int RANDOM_LINES = 240;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 100;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   voxels_owed;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   stall_cycles;

    vl3r_cmd_if   cmd_ch ();
    vl3r_voxel_if voxel_ch ();

    voxel_line_3d_rasterizer #(
        .EDGE_LEN (8)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .voxel (voxel_ch)
    );

    vl3r_line_checker line_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .voxel       (voxel_ch),
        .fail_count  (fail_count),
        .voxels_owed (voxels_owed)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // voxel sink with random back-pressure
    always @(negedge clk)
    begin
        voxel_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (voxel_ch.valid && voxel_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one line command, with a random gap first
    task automatic send_line(input int sx, input int sy, input int sz,
                             input int ex, input int ey, input int ez,
                             input int r, input int g, input int b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.start_x     <= coord_t'(sx);
        cmd_ch.start_y     <= coord_t'(sy);
        cmd_ch.start_z     <= coord_t'(sz);
        cmd_ch.end_x       <= coord_t'(ex);
        cmd_ch.end_y       <= coord_t'(ey);
        cmd_ch.end_z       <= coord_t'(ez);
        cmd_ch.red_level   <= level_t'(r);
        cmd_ch.green_level <= level_t'(g);
        cmd_ch.blue_level  <= level_t'(b);
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // hold off until every queued voxel has come out
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (voxels_owed != 0)
        begin
            @(negedge clk);
        end
    endtask

    // coordinate a short distance from c, kept inside the cube
    function automatic int near_coord(input int c);
        int n;
        n = c + $urandom_range(0, 4) - 2;
        if (n < 0)
            n = 0;
        if (n > 7)
            n = 7;
        return n;
    endfunction

    // colour level: mostly random, sometimes an extreme
    function automatic int pick_level();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 0;
        else if (sel == 1)
            return 4095;
        else
            return $urandom_range(0, 4095);
    endfunction

    initial
    begin
        int phase;
        int n;
        int shape;
        int sx;
        int sy;
        int sz;
        int ex;
        int ey;
        int ez;

        clk                = 1'b0;
        rst_n              = 1'b0;
        stall_cycles       = 0;
        send_idle_pct      = 24;
        recv_idle_pct      = 83;
        cmd_ch.valid       = 1'b0;
        cmd_ch.start_x     = '0;
        cmd_ch.start_y     = '0;
        cmd_ch.start_z     = '0;
        cmd_ch.end_x       = '0;
        cmd_ch.end_y       = '0;
        cmd_ch.end_z       = '0;
        cmd_ch.red_level   = '0;
        cmd_ch.green_level = '0;
        cmd_ch.blue_level  = '0;
        voxel_ch.ready     = 1'b0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed lines: equal endpoints, each axis both ways, ties, slopes
        send_line(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_line(7, 7, 7, 7, 7, 7, 4095, 4095, 4095);
        send_line(0, 0, 0, 7, 0, 0, 'haaa, 'h555, 'haaa);
        send_line(7, 0, 0, 0, 0, 0, 'h555, 'haaa, 'h555);
        send_line(0, 0, 0, 0, 7, 0, 1, 2, 4);
        send_line(0, 0, 0, 0, 0, 7, 2048, 1024, 512);
        send_line(0, 0, 7, 0, 0, 0, 4095, 0, 4095);
        send_line(0, 0, 0, 7, 7, 7, 0, 4095, 0);
        send_line(7, 7, 7, 0, 0, 0, 'h123, 'h456, 'h789);
        send_line(0, 0, 3, 5, 5, 0, 'hfff, 'h000, 'h800);
        send_line(3, 0, 0, 0, 6, 6, 'h001, 'h800, 'hfff);
        send_line(0, 7, 0, 7, 0, 3, 'h7ff, 'hf00, 'h0f0);
        send_line(2, 7, 1, 5, 0, 6, 'h00f, 'hf0f, 'h3c3);
        send_line(6, 1, 7, 1, 4, 0, 'hc3c, 'h5a5, 'ha5a);
        send_line(7, 0, 0, 0, 3, 7, 'h999, 'h666, 'h333);
        send_line(7, 1, 6, 0, 6, 2, 'heee, 'h111, 'hddd);
        send_line(1, 2, 3, 2, 3, 4, 'hbbb, 'h444, 'h777);
        send_line(5, 5, 5, 5, 5, 6, 'h888, 'hccc, 'h222);
        send_line(4, 4, 4, 3, 4, 4, 'h0ff, 'hff0, 'hf0f);
        wait_drained();

        // random lines over three back-pressure phases
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 83;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            for (n = 0; n < RANDOM_LINES / 3; n++)
            begin
                sx    = $urandom_range(0, 7);
                sy    = $urandom_range(0, 7);
                sz    = $urandom_range(0, 7);
                shape = $urandom_range(0, 19);
                if (shape < 3)
                begin
                    // equal endpoints
                    ex = sx;
                    ey = sy;
                    ez = sz;
                end
                else if (shape < 7)
                begin
                    // short line
                    ex = near_coord(sx);
                    ey = near_coord(sy);
                    ez = near_coord(sz);
                end
                else
                begin
                    ex = $urandom_range(0, 7);
                    ey = $urandom_range(0, 7);
                    ez = $urandom_range(0, 7);
                end
                send_line(sx, sy, sz, ex, ey, ez, pick_level(), pick_level(), pick_level());

                // occasional full drain before the next command
                if ($urandom_range(0, 24) == 0)
                begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        // let any stray voxel show up
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && voxels_owed == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### voxel_line_3d_rasterizer.f
sv/vl3r_pkg.sv
sv/vl3r_if.sv
sv/vl3r_setup.sv
sv/vl3r_div.sv
sv/voxel_line_3d_rasterizer.sv
sv/vl3r_checker.sv
sim/vl3r_line_checker.sv
sim/tb_voxel_line_3d_rasterizer.sv
